// ===== rtl/core/sks_pkg.sv =====
// Shared constants, opcodes, engine states and the result record of the sorted key set.
package sks_pkg;

   localparam int OPCODE_W         = 2;
   localparam int KEY_IN_W         = 32;
   localparam int OUT_W            = 9;
   localparam int DEF_CAPACITY     = 256;
   localparam int DEF_KEY_WIDTH    = 32;

   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TEST   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_PLAN,
      ST_SHIFT,
      ST_TAIL,
      ST_DONE
   } sks_state_type;

   typedef struct packed {
      logic             found;
      logic [OUT_W-1:0] position;
      logic [OUT_W-1:0] entry_count;
      logic             status;
   } sks_result_type;

endpackage

// ===== rtl/core/sks_engine.sv =====
// Key table memory with the binary search and shift sequencer of the sorted key set.
module sks_engine #(
   parameter int CAPACITY  = sks_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sks_pkg::OPCODE_W-1:0]  start_opcode,
   input  logic [KEY_WIDTH-1:0]          start_key,
   output logic                          ready,
   output logic                          done_valid,
   input  logic                          done_take,
   output sks_pkg::sks_result_type       done_result
);
   import sks_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [KEY_WIDTH-1:0] mem [CAPACITY];
   logic [KEY_WIDTH-1:0] rdata_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   sks_state_type        state_ff, state_in;
   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic                 up_ff, up_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_dest_ff, wr_dest_in;
   sks_result_type       result_ff, result_in;

   logic [CW-1:0]        mid_calc;
   logic                 grow;
   logic                 shrink;
   logic                 full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign full     = (count_ff >= CAP_CNT);
   assign grow     = (op_ff == OP_ADD) && !found_ff && !full;
   assign shrink   = (op_ff == OP_REMOVE) && found_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      src_in     = src_ff;
      remain_in  = remain_ff;
      up_in      = up_ff;
      wr_pend_in = wr_pend_ff;
      wr_dest_in = wr_dest_ff;
      result_in  = result_ff;
      rd_en      = 1'b0;
      rd_addr    = src_ff;
      wr_en      = 1'b0;
      wr_addr    = wr_dest_ff;
      wr_data    = rdata_ff;
      ready      = 1'b0;
      done_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               op_in    = start_opcode;
               key_in   = start_key;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(mid_calc);
               mid_in   = AW'(mid_calc);
               state_in = ST_CMP;
            end else begin
               pos_in   = lo_ff;
               state_in = ST_PLAN;
            end
         end
         ST_CMP: begin
            if (key_ff < rdata_ff) begin
               hi_in    = CW'(mid_ff);
               state_in = ST_SEARCH;
            end else if (key_ff > rdata_ff) begin
               lo_in    = CW'(mid_ff) + CW'(1);
               state_in = ST_SEARCH;
            end else begin
               found_in = 1'b1;
               pos_in   = CW'(mid_ff);
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            wr_pend_in = 1'b0;
            if (grow) begin
               up_in     = 1'b1;
               src_in    = AW'(count_ff - CW'(1));
               remain_in = count_ff - pos_ff;
            end else if (shrink) begin
               up_in     = 1'b0;
               src_in    = AW'(pos_ff + CW'(1));
               remain_in = count_ff - pos_ff - CW'(1);
            end else begin
               remain_in = '0;
            end
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // Each cycle writes the entry read in the cycle before and reads the next one.
            wr_en = wr_pend_ff;
            if (remain_ff != '0) begin
               rd_en      = 1'b1;
               wr_pend_in = 1'b1;
               wr_dest_in = up_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               src_in     = up_ff ? src_ff - AW'(1) : src_ff + AW'(1);
               remain_in  = remain_ff - CW'(1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (grow) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(pos_ff);
               wr_data  = key_ff;
               count_in = count_ff + CW'(1);
            end else if (shrink) begin
               count_in = count_ff - CW'(1);
            end
            result_in.found       = found_ff;
            result_in.position    = OUT_W'(pos_ff);
            result_in.entry_count = OUT_W'(count_in);
            result_in.status      = (op_ff == OP_ADD) && !found_ff && full;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      src_ff     <= src_in;
      remain_ff  <= remain_in;
      up_ff      <= up_in;
      wr_dest_ff <= wr_dest_in;
      result_ff  <= result_in;
   end

   assign done_result = result_ff;

   // A shift never reads the entry it writes in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write hit the same entry");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("key count above capacity");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (lo_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("search window out of range");

   a_grow_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL && grow) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not raise the count");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (done_valid && done_take) |=> !done_valid)
      else $error("result offered twice");

endmodule

// ===== rtl/core/sorted_key_set_core.sv =====
// Top level of the sorted key set: request intake, result register and the search engine.
//
// The block keeps a set of unsigned keys in ascending order in an on-chip table.
// A request beat carries an opcode (add, remove or test membership) and a key.
// Each request beat yields exactly one response beat with the found flag, the
// position where the key was found or would be inserted, the number of keys
// stored after the request, and a status bit that flags an add of a new key to a full table.
// Requests are handled one at a time: req_stall stays high from the acceptance
// of a request until its result has moved into the response register.
// A request runs a binary search over the stored keys (one memory read and
// one compare per step); an add or a remove then shifts the entries from the
// position upward, one entry per cycle through the single read and single write
// port of the table, before the result is written.
// Reset empties the set at once; the table contents are left as they are, since
// only entries below the key count are ever read.
// A stalled response holds in the response register; the next request may be
// accepted and worked on meanwhile, and its result waits in the engine.
module sorted_key_set_core #(
   parameter int CAPACITY  = sks_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sks_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [sks_pkg::KEY_IN_W-1:0]  req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [sks_pkg::OUT_W-1:0]     rsp_position,
   output logic [sks_pkg::OUT_W-1:0]     rsp_entry_count,
   output logic                          rsp_status
);
   import sks_pkg::*;

   logic           eng_ready;
   logic           eng_done;
   logic           eng_take;
   logic           req_beat;
   sks_result_type eng_result;

   logic           rsp_valid_ff, rsp_valid_in;
   sks_result_type rsp_data_ff, rsp_data_in;

   // Only the low KEY_WIDTH bits of the key take part; a wider table zero-extends it.
   logic [KEY_WIDTH-1:0] req_key_trim;
   assign req_key_trim = KEY_WIDTH'(req_key);

   assign req_stall = !eng_ready;
   assign req_beat  = req_valid && !req_stall;

   sks_engine #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (req_beat),
      .start_opcode (req_opcode),
      .start_key    (req_key_trim),
      .ready        (eng_ready),
      .done_valid   (eng_done),
      .done_take    (eng_take),
      .done_result  (eng_result)
   );

   // The engine hands over its result when the response register is empty or
   // is being emptied by a beat in this same cycle.
   assign eng_take = eng_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_data_ff.found;
   assign rsp_position    = rsp_data_ff.position;
   assign rsp_entry_count = rsp_data_ff.entry_count;
   assign rsp_status      = rsp_data_ff.status;

   // A held response must not be overwritten by a new result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled response changed");

   // A request is only taken while no other request is in the engine.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("engine took a second request");

   // Status is only ever raised by an add that found nothing.
   a_status_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |-> !rsp_data_ff.found)
      else $error("full flag on a found key");

endmodule
